[src/cccs_pkg.sv]
// ----------------------------------------------------------------------------
// cccs_pkg
// Types, character codes and class masks for the bracket class compiler and
// run splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cccs_pkg;

	localparam int unsigned MAX_TEXT_LEN = 65536;
	localparam int unsigned POS_W        = $clog2(MAX_TEXT_LEN + 1);
	localparam int unsigned CLASS_LIMIT  = 253;
	localparam int unsigned NUM_CODES    = 256;
	localparam int unsigned GRP_BITS     = 8;
	localparam int unsigned NUM_PARTS    = NUM_CODES / GRP_BITS;
	localparam int unsigned PARTS_PER_GRP = 8;
	localparam int unsigned NUM_GRPS     = NUM_PARTS / PARTS_PER_GRP;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_LBRACKET   = 8'h5B;
	localparam logic [7:0] CH_RBRACKET   = 8'h5D;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_DASH       = 8'h2D;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_ESCAPE     = 8'h1B;

	typedef enum logic [7:0] {
		PH_FIRST     = 8'b0000_0001,
		PH_OPEN      = 8'b0000_0010,
		PH_ITEM      = 8'b0000_0100,
		PH_ESC       = 8'b0000_1000,
		PH_AFTER     = 8'b0001_0000,
		PH_RANGE     = 8'b0010_0000,
		PH_RANGE_ESC = 8'b0100_0000,
		PH_DONE      = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_COMPILE = 2'd0,
		KIND_WORD    = 2'd1,
		KIND_SEP     = 2'd2
	} kind_t;

	typedef struct packed {
		logic        vld;
		kind_t       kind;
		logic [15:0] start;
		logic [16:0] run_end;
		logic        last;
	} slot_t;

	function automatic logic [NUM_CODES-1:0] digit_set();
		logic [NUM_CODES-1:0] m;
		m = '0;
		for (int i = 48; i <= 57; i++) m[i] = 1'b1;
		return m;
	endfunction

	function automatic logic [NUM_CODES-1:0] word_set();
		logic [NUM_CODES-1:0] m;
		m = digit_set();
		for (int i = 65; i <= 90; i++) m[i] = 1'b1;
		for (int i = 97; i <= 122; i++) m[i] = 1'b1;
		m[CH_UNDERSCORE] = 1'b1;
		return m;
	endfunction

	function automatic logic [NUM_CODES-1:0] space_set();
		logic [NUM_CODES-1:0] m;
		m = '0;
		m[32] = 1'b1;
		m[9]  = 1'b1;
		m[10] = 1'b1;
		m[13] = 1'b1;
		m[12] = 1'b1;
		return m;
	endfunction

	function automatic logic [NUM_CODES-1:0] limit_set();
		logic [NUM_CODES-1:0] m;
		m = '0;
		for (int i = 1; i < CLASS_LIMIT; i++) m[i] = 1'b1;
		return m;
	endfunction

	localparam logic [NUM_CODES-1:0] MASK_LIMIT  = limit_set();
	localparam logic [NUM_CODES-1:0] MASK_DIGIT  = digit_set();
	localparam logic [NUM_CODES-1:0] MASK_WORD   = word_set();
	localparam logic [NUM_CODES-1:0] MASK_SPACE  = space_set();
	localparam logic [NUM_CODES-1:0] MASK_NDIGIT = ~MASK_DIGIT & MASK_LIMIT;
	localparam logic [NUM_CODES-1:0] MASK_NWORD  = ~MASK_WORD & MASK_LIMIT;
	localparam logic [NUM_CODES-1:0] MASK_NSPACE = ~MASK_SPACE & MASK_LIMIT;

	// \d \D \w \W \s \S
	function automatic logic is_class_esc(logic [7:0] c);
		return (c == 8'h64) || (c == 8'h44) || (c == 8'h77) ||
			(c == 8'h57) || (c == 8'h73) || (c == 8'h53);
	endfunction

	function automatic logic [NUM_CODES-1:0] class_mask(logic [7:0] c);
		logic [NUM_CODES-1:0] m;
		case (c)
			8'h64:   m = MASK_DIGIT;
			8'h44:   m = MASK_NDIGIT;
			8'h77:   m = MASK_WORD;
			8'h57:   m = MASK_NWORD;
			8'h73:   m = MASK_SPACE;
			8'h53:   m = MASK_NSPACE;
			default: m = '0;
		endcase
		return m;
	endfunction

	// \0 \n \t \a \r \f \e, anything else stands for itself
	function automatic logic [7:0] char_escape(logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h30:   r = CH_NUL;
			8'h6E:   r = 8'h0A;
			8'h74:   r = 8'h09;
			8'h61:   r = 8'h07;
			8'h72:   r = 8'h0D;
			8'h66:   r = 8'h0C;
			8'h65:   r = CH_ESCAPE;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] pop8(logic [GRP_BITS-1:0] v);
		logic [3:0] s;
		s = '0;
		for (int i = 0; i < GRP_BITS; i++) s = s + 4'(v[i]);
		return s;
	endfunction

endpackage

`default_nettype wire

[src/char_class_compile_and_split_core.sv]
// ----------------------------------------------------------------------------
// char_class_compile_and_split_core
// Compiles a bracket class into a 256-entry membership table and splits text
// into maximal word / separator runs against that table.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  item      item_valid / item_ready      mode, data_byte, final_byte
//  result    result_valid / result_ready  kind, run_start, run_end,
//                                         member_count, last_out
//
//  One item is accepted per cycle while item_ready is high; table, parse and
//  text state update in the accept cycle. Results pass three pipeline stages
//  (table snapshot, 8-bit popcounts, group sums) and an output register. An
//  item with two results holds the output register until both are taken.
//  item_ready follows result_ready through the pipeline valid chain.
//  Reset clears the table, parse phase and text position at once.
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_compile_and_split_core
	import cccs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       kind,
	output logic [15:0]      run_start,
	output logic [16:0]      run_end,
	output logic [8:0]       member_count,
	output logic             last_out
);

	logic [NUM_CODES-1:0] tbl_q;
	phase_t               phase_q;
	logic                 neg_q;
	logic [7:0]           pend_q;
	logic [POS_W-1:0]     pos_q;
	logic [15:0]          start_q;
	logic                 word_q;

	logic acc;
	logic pat_acc;
	logic txt_acc;

	// ---------------- class compile ----------------
	phase_t               ph_n;
	phase_t               ist_phase;
	logic                 ist_close;
	logic                 neg_n;
	logic [7:0]           pend_n;
	logic                 close_byte;
	logic                 clear_tbl;
	logic                 rng_en;
	logic [7:0]           rng_hi;
	logic [NUM_CODES-1:0] cls_mask;
	logic [NUM_CODES-1:0] first_mask;
	logic                 fin_single;
	logic                 fin_close;
	logic [NUM_CODES-1:0] set_mask;
	logic [NUM_CODES-1:0] tbl_pre;
	logic [NUM_CODES-1:0] tbl_next;

	always_comb begin
		ist_close = (data_byte == CH_RBRACKET) || (data_byte == CH_NUL);
		if (ist_close) begin
			ist_phase = PH_DONE;
		end else if (data_byte == CH_BSLASH) begin
			ist_phase = PH_ESC;
		end else begin
			ist_phase = PH_AFTER;
		end
	end

	always_comb begin
		ph_n       = phase_q;
		neg_n      = neg_q;
		pend_n     = pend_q;
		close_byte = 1'b0;
		clear_tbl  = 1'b0;
		rng_en     = 1'b0;
		rng_hi     = pend_q;
		cls_mask   = '0;
		first_mask = '0;
		case (phase_q)
			PH_FIRST: begin
				clear_tbl = 1'b1;
				neg_n     = 1'b0;
				pend_n    = '0;
				if (data_byte == CH_LBRACKET) begin
					ph_n = PH_OPEN;
				end else begin
					first_mask = NUM_CODES'(1) << data_byte;
					ph_n       = PH_DONE;
				end
			end
			PH_OPEN: begin
				if (data_byte == CH_CARET) begin
					neg_n = 1'b1;
					ph_n  = PH_ITEM;
				end else begin
					close_byte = ist_close;
					ph_n       = ist_phase;
					if (ist_phase == PH_AFTER) pend_n = data_byte;
				end
			end
			PH_ITEM: begin
				close_byte = ist_close;
				ph_n       = ist_phase;
				if (ist_phase == PH_AFTER) pend_n = data_byte;
			end
			PH_ESC: begin
				cls_mask = class_mask(data_byte);
				pend_n   = is_class_esc(data_byte) ? CH_NUL : char_escape(data_byte);
				ph_n     = PH_AFTER;
			end
			PH_AFTER: begin
				if (data_byte == CH_DASH) begin
					ph_n = PH_RANGE;
				end else begin
					rng_en     = 1'b1;
					close_byte = ist_close;
					ph_n       = ist_phase;
					if (ist_phase == PH_AFTER) pend_n = data_byte;
				end
			end
			PH_RANGE: begin
				if (data_byte == CH_BSLASH) begin
					ph_n = PH_RANGE_ESC;
				end else begin
					rng_en = 1'b1;
					rng_hi = data_byte;
					ph_n   = PH_ITEM;
				end
			end
			PH_RANGE_ESC: begin
				rng_en = 1'b1;
				rng_hi = char_escape(data_byte);
				ph_n   = PH_ITEM;
			end
			default: ;
		endcase
	end

	// end of pattern: a pending single item is marked, an open class closes
	assign fin_single = final_byte && (ph_n == PH_AFTER) && (pend_n != CH_NUL);
	assign fin_close  = final_byte && (ph_n != PH_FIRST) && (ph_n != PH_DONE);

	always_comb begin
		for (int i = 0; i < NUM_CODES; i++) begin
			set_mask[i] = (rng_en && (pend_q != CH_NUL) &&
				(8'(i) >= pend_q) && (8'(i) <= rng_hi)) ||
				(fin_single && (8'(i) == pend_n));
		end
		tbl_pre = (clear_tbl ? '0 : tbl_q) | set_mask | cls_mask | first_mask;
		if ((close_byte || fin_close) && neg_n) begin
			tbl_next = ~tbl_pre & MASK_LIMIT;
		end else begin
			tbl_next = tbl_pre;
		end
	end

	// ---------------- text split ----------------
	logic             tp_ok;
	logic             cls;
	logic             tp_first;
	logic             brk;
	logic [15:0]      start_a;
	logic             word_a;
	logic [POS_W-1:0] pos_a;
	slot_t            r0_in;
	slot_t            r1_in;
	slot_t            run_brk;
	slot_t            run_fin;

	assign tp_ok    = pos_q < POS_W'(MAX_TEXT_LEN);
	assign cls      = tbl_q[data_byte];
	assign tp_first = pos_q == '0;
	assign brk      = tp_ok && !tp_first && (cls != word_q);
	assign word_a   = (tp_ok && (tp_first || brk)) ? cls : word_q;
	assign pos_a    = tp_ok ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		if (tp_ok && tp_first) begin
			start_a = '0;
		end else if (brk) begin
			start_a = pos_q[15:0];
		end else begin
			start_a = start_q;
		end
	end

	assign run_brk = '{vld: 1'b1, kind: word_q ? KIND_WORD : KIND_SEP, start: start_q,
		run_end: 17'(pos_q), last: !final_byte};
	assign run_fin = '{vld: 1'b1, kind: word_a ? KIND_WORD : KIND_SEP, start: start_a,
		run_end: 17'(pos_a), last: 1'b1};

	always_comb begin
		r0_in = '0;
		r1_in = '0;
		if (!mode) begin
			r0_in = '{vld: final_byte, kind: KIND_COMPILE, start: '0, run_end: '0,
				last: 1'b1};
		end else if (brk) begin
			r0_in = run_brk;
			if (final_byte) r1_in = run_fin;
		end else if (final_byte) begin
			r0_in = run_fin;
		end
	end

	// ---------------- state update ----------------
	assign acc     = item_valid && item_ready;
	assign pat_acc = acc && !mode;
	assign txt_acc = acc && mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q   <= '0;
			phase_q <= PH_FIRST;
			neg_q   <= 1'b0;
			pend_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			word_q  <= 1'b0;
		end else begin
			if (pat_acc) begin
				tbl_q   <= tbl_next;
				phase_q <= final_byte ? PH_FIRST : ph_n;
				neg_q   <= neg_n;
				pend_q  <= pend_n;
			end
			if (txt_acc) begin
				if (final_byte) begin
					pos_q   <= '0;
					start_q <= '0;
					word_q  <= 1'b0;
				end else begin
					pos_q   <= pos_a;
					start_q <= start_a;
					word_q  <= word_a;
				end
			end
		end
	end

	// ---------------- result pipeline ----------------
	logic                           v1_q, v2_q, v3_q, out_v_q, sel_q;
	logic                           mv1, mv2, mv3, out_free;
	slot_t                          r0_s1, r1_s1, r0_s2, r1_s2, r0_s3, r1_s3, r0_q, r1_q;
	logic [NUM_CODES-1:0]           snap_s1;
	logic [NUM_PARTS-1:0][3:0]      part_s2;
	logic [NUM_GRPS-1:0][6:0]       grp_s3;
	logic [8:0]                     cnt_q;
	logic [8:0]                     cnt_sum;
	slot_t                          cur;

	assign out_free   = !out_v_q || (result_ready && (sel_q || !r1_q.vld));
	assign mv3        = !v3_q || out_free;
	assign mv2        = !v2_q || mv3;
	assign mv1        = !v1_q || mv2;
	assign item_ready = mv1;

	always_comb begin
		cnt_sum = '0;
		for (int k = 0; k < NUM_GRPS; k++) cnt_sum = cnt_sum + 9'(grp_s3[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			out_v_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (mv1) v1_q <= acc && r0_in.vld;
			if (mv2) v2_q <= v1_q;
			if (mv3) v3_q <= v2_q;
			if (out_free) begin
				out_v_q <= v3_q;
				sel_q   <= 1'b0;
			end else if (result_ready) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			r0_s1 <= r0_in;
			r1_s1 <= r1_in;
			if (pat_acc && final_byte) snap_s1 <= tbl_next;
		end
		if (mv2) begin
			r0_s2 <= r0_s1;
			r1_s2 <= r1_s1;
			for (int g = 0; g < NUM_PARTS; g++) begin
				part_s2[g] <= pop8(snap_s1[g*GRP_BITS +: GRP_BITS]);
			end
		end
		if (mv3) begin
			r0_s3 <= r0_s2;
			r1_s3 <= r1_s2;
			for (int k = 0; k < NUM_GRPS; k++) begin
				grp_s3[k] <= 7'(part_s2[k*PARTS_PER_GRP + 0]) +
					7'(part_s2[k*PARTS_PER_GRP + 1]) +
					7'(part_s2[k*PARTS_PER_GRP + 2]) +
					7'(part_s2[k*PARTS_PER_GRP + 3]) +
					7'(part_s2[k*PARTS_PER_GRP + 4]) +
					7'(part_s2[k*PARTS_PER_GRP + 5]) +
					7'(part_s2[k*PARTS_PER_GRP + 6]) +
					7'(part_s2[k*PARTS_PER_GRP + 7]);
			end
		end
		if (out_free) begin
			r0_q  <= r0_s3;
			r1_q  <= r1_s3;
			cnt_q <= cnt_sum;
		end
	end

	assign cur          = sel_q ? r1_q : r0_q;
	assign result_valid = out_v_q;
	assign kind         = cur.kind;
	assign run_start    = cur.start;
	assign run_end      = cur.run_end;
	assign member_count = (cur.kind == KIND_COMPILE) ? cnt_q : '0;
	assign last_out     = cur.last;

	// ---------------- checks ----------------
	a_second_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && sel_q |-> r1_q.vld)
		else $error("second result shown without a second slot");

	a_compile_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_COMPILE) |-> last_out && (run_end == '0))
		else $error("compile result with run fields or not last");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind != KIND_COMPILE) |-> run_end > {1'b0, run_start})
		else $error("run end not past run start");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && !out_free |=> v3_q)
		else $error("stage 3 transaction dropped while output blocked");

	a_pattern_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pat_acc && final_byte |=> phase_q == PH_FIRST)
		else $error("parser not rearmed after final pattern byte");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pattern and text bytes into char_class_compile_and_split_core and
// checks every result against a cycle-free model of the class table, the
// pattern parser and the run splitter. A short table of directed bytes comes
// first, then randomized classes, noise, texts, interleaved streams and one
// text that runs past the position limit.
// ----------------------------------------------------------------------------

module tb_top;
	import cccs_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] first_pos;
		logic [16:0] end_pos;
		logic [8:0]  count;
		logic        last;
	} run_res_t;

	typedef struct packed {
		logic        m;
		logic [7:0]  b;
		logic        fin;
		logic        typed;
		kind_t       kind;
		logic [15:0] first_pos;
		logic [16:0] end_pos;
		logic [8:0]  count;
	} byte_row_t;

	localparam string ESC_CHARS   = "0ntarfedDwWsS-]^\\x";
	localparam string CLASS_CHARS = "dDwWsS";
	localparam string TEXT_PUNCT  = " \t\n\r,.;-";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        mode = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] run_start;
	logic [16:0] run_end;
	logic [8:0]  member_count;
	logic        last_out;

	// class table, parser and splitter state as seen by the checker
	logic [255:0] member_tab = '0;
	phase_t       parse_ph = PH_FIRST;
	logic         neg_armed = 1'b0;
	logic [7:0]   first_code = 8'h00;
	int unsigned  text_pos = 0;
	logic [15:0]  run_from = '0;
	logic         run_is_word = 1'b0;

	run_res_t awaited_results[$];
	int       mismatch_count = 0;
	int       burst_left = 0;
	int       stall_style = 0;
	int       stall_left = 0;
	int       stall_tick = 0;

	byte_row_t dir_rows [25] = '{
		'{1'b1, "a",         1'b1, 1'b1, KIND_SEP,     16'd0, 17'd1, 9'd0},
		'{1'b0, 8'h00,       1'b1, 1'b1, KIND_COMPILE, 16'd0, 17'd0, 9'd1},
		'{1'b1, 8'h00,       1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b1, 8'hFF,       1'b1, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, 8'hFF,       1'b1, 1'b1, KIND_COMPILE, 16'd0, 17'd0, 9'd1},
		'{1'b0, CH_LBRACKET, 1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_CARET,    1'b1, 1'b1, KIND_COMPILE, 16'd0, 17'd0, 9'd252},
		'{1'b0, CH_LBRACKET, 1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_BSLASH,   1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "D",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_BSLASH,   1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "s",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "a",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_DASH,     1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_BSLASH,   1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "e",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_BSLASH,   1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "0",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_DASH,     1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "~",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_NUL,      1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "q",         1'b1, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_LBRACKET, 1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, "w",         1'b0, 1'b0, KIND_COMPILE, 16'd0, 17'd0, 9'd0},
		'{1'b0, CH_DASH,     1'b1, 1'b1, KIND_COMPILE, 16'd0, 17'd0, 9'd0}
	};

	char_class_compile_and_split_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.run_start    (run_start),
		.run_end      (run_end),
		.member_count (member_count),
		.last_out     (last_out)
	);

	always #4 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void mark_codes(int lo, int hi);
		for (int i = lo; i <= hi && i < 256; i++) member_tab[i] = 1'b1;
	endfunction

	function automatic void mark_range(logic [7:0] f, logic [7:0] l);
		if (f != 8'h00 && f <= l) mark_codes(f, l);
	endfunction

	function automatic logic [7:0] esc_code(logic [7:0] b);
		case (b)
			"0": return CH_NUL;
			"n": return 8'h0A;
			"t": return 8'h09;
			"a": return 8'h07;
			"r": return 8'h0D;
			"f": return 8'h0C;
			"e": return CH_ESCAPE;
			default: return b;
		endcase
	endfunction

	function automatic logic apply_class_esc(logic [7:0] b);
		logic skip;
		case (b)
			"d": mark_codes("0", "9");
			"w": begin
				mark_codes("a", "z");
				mark_codes("A", "Z");
				mark_codes("0", "9");
				member_tab[CH_UNDERSCORE] = 1'b1;
			end
			"s": begin
				member_tab[" "] = 1'b1;
				member_tab[8'h09] = 1'b1;
				member_tab[8'h0A] = 1'b1;
				member_tab[8'h0D] = 1'b1;
				member_tab[8'h0C] = 1'b1;
			end
			"D", "W", "S": begin
				for (int i = 1; i < 253; i++) begin
					if (b == "D")
						skip = (i >= "0" && i <= "9");
					else if (b == "W")
						skip = (i >= "0" && i <= "9") || (i >= "A" && i <= "Z") ||
							(i >= "a" && i <= "z") || i == CH_UNDERSCORE;
					else
						skip = (i == " " || i == 8'h09 || i == 8'h0A || i == 8'h0D ||
							i == 8'h0C);
					if (!skip) member_tab[i] = 1'b1;
				end
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void close_class();
		if (neg_armed) begin
			for (int i = 0; i < 256; i++) begin
				if (member_tab[i])
					member_tab[i] = 1'b0;
				else if (i > 0 && i < 253)
					member_tab[i] = 1'b1;
			end
		end
		parse_ph = PH_DONE;
	endfunction

	function automatic void start_item(logic [7:0] b);
		if (b == CH_RBRACKET || b == CH_NUL)
			close_class();
		else if (b == CH_BSLASH)
			parse_ph = PH_ESC;
		else begin
			first_code = b;
			parse_ph = PH_AFTER;
		end
	endfunction

	// Returns the number of results the byte causes, in r0 then r1.
	function automatic int compile_or_split(logic m, logic [7:0] b, logic fin,
			output run_res_t r0, output run_res_t r1);
		int n;
		logic cls;
		run_res_t r;
		n = 0;
		r0 = '0;
		r1 = '0;
		if (!m) begin
			case (parse_ph)
				PH_FIRST: begin
					member_tab = '0;
					neg_armed = 1'b0;
					first_code = 8'h00;
					if (b == CH_LBRACKET)
						parse_ph = PH_OPEN;
					else begin
						member_tab[b] = 1'b1;
						parse_ph = PH_DONE;
					end
				end
				PH_OPEN: begin
					if (b == CH_CARET) begin
						neg_armed = 1'b1;
						parse_ph = PH_ITEM;
					end else
						start_item(b);
				end
				PH_ITEM: start_item(b);
				PH_ESC: begin
					first_code = apply_class_esc(b) ? 8'h00 : esc_code(b);
					parse_ph = PH_AFTER;
				end
				PH_AFTER: begin
					if (b == CH_DASH)
						parse_ph = PH_RANGE;
					else begin
						mark_range(first_code, first_code);
						start_item(b);
					end
				end
				PH_RANGE: begin
					if (b == CH_BSLASH)
						parse_ph = PH_RANGE_ESC;
					else begin
						mark_range(first_code, b);
						parse_ph = PH_ITEM;
					end
				end
				PH_RANGE_ESC: begin
					mark_range(first_code, esc_code(b));
					parse_ph = PH_ITEM;
				end
				default: ;
			endcase
			if (!fin) return 0;
			if (parse_ph == PH_AFTER) mark_range(first_code, first_code);
			if (parse_ph != PH_DONE && parse_ph != PH_FIRST) close_class();
			parse_ph = PH_FIRST;
			r0 = '{KIND_COMPILE, 16'd0, 17'd0, 9'($countones(member_tab)), 1'b1};
			return 1;
		end
		if (text_pos < MAX_TEXT_LEN) begin
			cls = member_tab[b];
			if (text_pos == 0) begin
				run_from = '0;
				run_is_word = cls;
			end else if (cls != run_is_word) begin
				r0 = '{run_is_word ? KIND_WORD : KIND_SEP, run_from, 17'(text_pos), 9'd0, !fin};
				n = 1;
				run_from = text_pos[15:0];
				run_is_word = cls;
			end
			text_pos++;
		end
		if (fin) begin
			r = '{run_is_word ? KIND_WORD : KIND_SEP, run_from, 17'(text_pos), 9'd0, 1'b1};
			if (n == 0) r0 = r; else r1 = r;
			n++;
			text_pos = 0;
			run_from = '0;
			run_is_word = 1'b0;
		end
		return n;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Presents one byte; sender bursts and gaps are handled here.
	task automatic send_item(logic m, logic [7:0] b, logic fin, logic use_row,
			byte_row_t row, logic steady);
		int gap;
		int n;
		run_res_t r0, r1;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0 && !steady) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		mode <= m;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (!item_ready);
		n = compile_or_split(m, b, fin, r0, r1);
		if (use_row)
			awaited_results.push_back(run_res_t'{row.kind, row.first_pos, row.end_pos,
				row.count, 1'b1});
		else begin
			if (n > 0) awaited_results.push_back(r0);
			if (n > 1) awaited_results.push_back(r1);
		end
	endtask

	task automatic send_bytes(logic m, logic [7:0] q[$], logic close_it);
		foreach (q[i]) send_item(m, q[i], close_it && i == q.size() - 1, 1'b0, '0, 1'b0);
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_lit();
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] pick_text();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range("a", "z"));
			1: return 8'($urandom_range("0", "9"));
			2: return TEXT_PUNCT[$urandom_range(0, TEXT_PUNCT.len() - 1)];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_esc();
		if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
		return ESC_CHARS[$urandom_range(0, ESC_CHARS.len() - 1)];
	endfunction

	// Class with random content, sometimes left open or ending in a dash or backslash; junk counts trailing ignored bytes.
	task automatic make_class(output logic [7:0] q[$], output int junk);
		logic [7:0] f;
		q = {};
		junk = 0;
		q.push_back(CH_LBRACKET);
		if ($urandom_range(0, 2) == 0) q.push_back(CH_CARET);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 4))
				0: q.push_back(pick_lit());
				1: begin
					q.push_back(CH_BSLASH);
					q.push_back(pick_esc());
				end
				4: begin
					q.push_back(CH_BSLASH);
					q.push_back(CLASS_CHARS[$urandom_range(0, CLASS_CHARS.len() - 1)]);
				end
				default: begin
					f = pick_lit();
					q.push_back(f);
					q.push_back(CH_DASH);
					if ($urandom_range(0, 3) == 0) begin
						q.push_back(CH_BSLASH);
						q.push_back(pick_esc());
					end else
						q.push_back(f + 8'($urandom_range(0, 30)));
				end
			endcase
		end
		case ($urandom_range(0, 9))
			7: begin
				q.push_back(pick_lit());
				q.push_back(CH_DASH);
			end
			8: q.push_back(CH_BSLASH);
			9: ;
			default: begin
				q.push_back(CH_RBRACKET);
				junk = $urandom_range(0, 2);
				repeat (junk) q.push_back(pick_lit());
			end
		endcase
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end else
			stall_left--;
		stall_tick++;
		case (stall_style)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (stall_tick % 4 == 0);
			default: result_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		run_res_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0)
				report_mismatch($sformatf("unexpected transaction kind=%0d start=%0d end=%0d",
					kind, run_start, run_end));
			else begin
				want = awaited_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (run_start !== want.first_pos)
					report_mismatch($sformatf("run_start %0d, want %0d", run_start,
						want.first_pos));
				if (run_end !== want.end_pos)
					report_mismatch($sformatf("run_end %0d, want %0d", run_end, want.end_pos));
				if (member_count !== want.count)
					report_mismatch($sformatf("member_count %0d, want %0d", member_count,
						want.count));
				if (last_out !== want.last)
					report_mismatch($sformatf("last_out %0d, want %0d", last_out, want.last));
			end
		end
	end

	initial begin
		logic [7:0] pat[$];
		logic [7:0] txt[$];
		int junk;
		int item_total;
		int sel;
		item_total = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].m, dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i], 1'b0);
		drain_results();

		while (item_total < 1650) begin
			sel = $urandom_range(0, 99);
			if (sel < 38) begin
				make_class(pat, junk);
				send_bytes(1'b0, pat, 1'b1);
				item_total += pat.size() - junk;
			end else if (sel < 46) begin
				pat = {};
				repeat ($urandom_range(1, 5)) pat.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0) pat[0] = CH_LBRACKET;
				send_bytes(1'b0, pat, 1'b1);
				item_total += pat.size();
			end else if (sel < 93) begin
				txt = {};
				repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 3 : 30))
					txt.push_back(pick_text());
				send_bytes(1'b1, txt, 1'b1);
				item_total += txt.size();
			end else begin
				// pattern compiled in the middle of an open text
				txt = {};
				repeat ($urandom_range(1, 10)) txt.push_back(pick_text());
				send_bytes(1'b1, txt, 1'b0);
				item_total += txt.size();
				make_class(pat, junk);
				send_bytes(1'b0, pat, 1'b1);
				item_total += pat.size() - junk;
				txt = {};
				repeat ($urandom_range(1, 10)) txt.push_back(pick_text());
				send_bytes(1'b1, txt, 1'b1);
				item_total += txt.size();
			end
			if ($urandom_range(0, 99) == 0) drain_results();
		end
		drain_results();

		// text longer than the position range
		pat = {CH_LBRACKET, "a", CH_DASH, "z", CH_RBRACKET};
		send_bytes(1'b0, pat, 1'b1);
		for (int i = 0; i < MAX_TEXT_LEN + 4; i++)
			send_item(1'b1, (i % 9000 == 8999 || i > MAX_TEXT_LEN) ? 8'h20 : 8'h61,
				i == MAX_TEXT_LEN + 3, 1'b0, '0, 1'b1);

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
src/cccs_pkg.sv
src/char_class_compile_and_split_core.sv
tb/tb_top.sv
